>>> rtl/rms_pkg.sv
`default_nettype none

package rms_pkg;

   // fixed field widths of the ports
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned RMS_W       = 16;
   localparam int unsigned COUNT_OUT_W = 11;

   // commands from the controller to the datapath
   typedef struct packed {
      logic take;        // input word accepted this cycle
      logic div_load;    // start divide: latch final sum, clear accumulator
      logic div_step;    // one quotient bit
      logic root_load;   // start root: latch quotient
      logic root_step;   // one root bit
      logic emit;        // latch result, clear set state
   } rms_cmd_type;

endpackage

`default_nettype wire

>>> rtl/rms_ctrl.sv
`default_nettype none

module rms_ctrl
   import rms_pkg::*;
#(
   parameter int unsigned SUM_W  = 41,
   parameter int unsigned ROOT_W = 21
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        req_last,
   output logic             busy,
   output logic             rsp_valid,
   output rms_cmd_type      cmd
);

   localparam int unsigned STEP_W = $clog2(SUM_W);

   typedef enum logic [2:0] {
      IDLE,
      LOAD,
      DIV,
      RLOAD,
      ROOT,
      OUT
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            IDLE: begin
               if (start && req_last) begin
                  state_ff <= LOAD;
               end
            end
            LOAD: begin
               step_ff  <= '0;
               state_ff <= DIV;
            end
            DIV: begin
               if (step_ff == STEP_W'(SUM_W - 1)) begin
                  step_ff  <= '0;
                  state_ff <= RLOAD;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            RLOAD: begin
               state_ff <= ROOT;
            end
            ROOT: begin
               if (step_ff == STEP_W'(ROOT_W - 1)) begin
                  step_ff  <= '0;
                  state_ff <= OUT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            OUT: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.take      = start && (state_ff == IDLE);
      cmd.div_load  = (state_ff == LOAD);
      cmd.div_step  = (state_ff == DIV);
      cmd.root_load = (state_ff == RLOAD);
      cmd.root_step = (state_ff == ROOT);
      cmd.emit      = (state_ff == OUT);
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/rms_dp.sv
`default_nettype none

module rms_dp
   import rms_pkg::*;
#(
   parameter int unsigned MAX_SAMPLES = 1024,
   parameter int unsigned SAMPLE_BITS = 16,
   parameter int unsigned CNT_W       = 11,
   parameter int unsigned SUM_W       = 41,
   parameter int unsigned ROOT_W      = 21
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rms_cmd_type            cmd,
   input  wire logic [SAMPLE_W-1:0]    req_sample,
   output logic [RMS_W-1:0]            rsp_rms_value,
   output logic [COUNT_OUT_W-1:0]      rsp_sample_count,
   output logic                        rsp_overflow
);

   localparam int unsigned SQ_W  = 2 * SAMPLE_BITS - 1;
   localparam int unsigned RAD_W = 2 * ROOT_W;

   // ---- square of the sample magnitude
   logic [SAMPLE_BITS-1:0]   raw_u;
   logic [SAMPLE_BITS-1:0]   mag;
   logic [2*SAMPLE_BITS-1:0] prod;

   assign raw_u = SAMPLE_BITS'(req_sample);
   assign mag   = raw_u[SAMPLE_BITS-1] ? (~raw_u + 1'b1) : raw_u;
   assign prod  = mag * mag;

   // ---- accumulator
   logic [SQ_W-1:0]  sq_ff;
   logic             sq_vld_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] count_ff;
   logic             dropped_ff;
   logic             room;
   logic [SUM_W:0]   sum_ext;
   logic [SUM_W-1:0] sum_in;

   assign room    = (count_ff < CNT_W'(MAX_SAMPLES));
   assign sum_ext = {1'b0, sum_ff} + (SUM_W + 1)'(sq_ff);

   always_comb begin
      sum_in = sum_ff;
      if (sq_vld_ff) begin
         sum_in = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= prod[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff  <= 1'b0;
         sum_ff     <= '0;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         sq_vld_ff <= cmd.take && room;
         if (cmd.div_load) begin
            sum_ff <= '0;
         end else begin
            sum_ff <= sum_in;
         end
         if (cmd.emit) begin
            count_ff   <= '0;
            dropped_ff <= 1'b0;
         end else if (cmd.take) begin
            if (room) begin
               count_ff <= count_ff + 1'b1;
            end else begin
               dropped_ff <= 1'b1;
            end
         end
      end
   end

   // ---- restoring divider, one quotient bit per cycle
   logic [CNT_W-1:0] div_rem_ff;
   logic [SUM_W-1:0] quo_ff;
   logic [CNT_W:0]   div_trial;
   logic [CNT_W:0]   div_diff;
   logic             div_ge;

   assign div_trial = {div_rem_ff, quo_ff[SUM_W-1]};
   assign div_diff  = div_trial - {1'b0, count_ff};
   assign div_ge    = (div_trial >= {1'b0, count_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         div_rem_ff <= '0;
         quo_ff     <= sum_in;
      end else if (cmd.div_step) begin
         div_rem_ff <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
         quo_ff     <= {quo_ff[SUM_W-2:0], div_ge};
      end
   end

   // ---- digit-by-digit square root, one root bit per cycle
   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W+1:0] srem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [ROOT_W+3:0] sq_cur;
   logic [ROOT_W+3:0] sq_trial;
   logic [ROOT_W+3:0] sq_diff;
   logic              sq_ge;

   assign sq_cur   = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_diff  = sq_cur - sq_trial;
   assign sq_ge    = (sq_cur >= sq_trial);

   always_ff @(posedge clock) begin
      if (cmd.root_load) begin
         rad_ff  <= RAD_W'(quo_ff);
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         srem_ff <= sq_ge ? sq_diff[ROOT_W+1:0] : sq_cur[ROOT_W+1:0];
         root_ff <= {root_ff[ROOT_W-2:0], sq_ge};
      end
   end

   // ---- result word
   logic [RMS_W-1:0] root_sat;

   generate
      if (ROOT_W > RMS_W) begin : g_sat
         assign root_sat = (|root_ff[ROOT_W-1:RMS_W]) ? {RMS_W{1'b1}}
                                                      : root_ff[RMS_W-1:0];
      end else begin : g_ext
         assign root_sat = RMS_W'(root_ff);
      end
   endgenerate

   logic [RMS_W-1:0]       rms_ff;
   logic [COUNT_OUT_W-1:0] cnt_out_ff;
   logic                   ovf_ff;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rms_ff     <= root_sat;
         cnt_out_ff <= COUNT_OUT_W'(count_ff);
         ovf_ff     <= dropped_ff;
      end
   end

   assign rsp_rms_value    = rms_ff;
   assign rsp_sample_count = cnt_out_ff;
   assign rsp_overflow     = ovf_ff;

endmodule

`default_nettype wire

>>> rtl/root_mean_square_top.sv
// After the edge that takes the last word, the sequencer runs LOAD, the DIV loop, RLOAD,
//   the ROOT loop and OUT, then raises rsp_valid.
// Throughput: one sample word per cycle while a set accumulates; busy is high
//   from the last word until the result cycle.
// Reset: synchronous, active high; clears the running sum, count and overflow flag.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
`default_nettype none

module root_mean_square_top
   import rms_pkg::*;
#(
   parameter int unsigned MAX_SAMPLES = 1024,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // sample words
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [SAMPLE_W-1:0]    req_sample,
   input  wire logic                   req_last,
   // result words
   output logic                        rsp_valid,
   output logic [RMS_W-1:0]            rsp_rms_value,
   output logic [COUNT_OUT_W-1:0]      rsp_sample_count,
   output logic                        rsp_overflow
);

   // count must hold MAX_SAMPLES itself
   localparam int unsigned CNT_W    = $clog2(MAX_SAMPLES + 1);
   // sum of squares: largest square is 2^(2*SAMPLE_BITS-2); saturates at 64 bits
   localparam int unsigned SUM_FULL = 2 * SAMPLE_BITS - 2 + CNT_W;
   localparam int unsigned SUM_W    = (SUM_FULL > 64) ? 64 : SUM_FULL;
   // one root bit per pair of radicand bits
   localparam int unsigned ROOT_W   = (SUM_W + 1) / 2;

   rms_cmd_type cmd;

   // Sequencer: idle/accumulate, then divide, then square root, then strobe.
   rms_ctrl #(
      .SUM_W  (SUM_W),
      .ROOT_W (ROOT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_last  (req_last),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Datapath: squarer, accumulator, bit-serial divider and root, result regs.
   rms_dp #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .SUM_W       (SUM_W),
      .ROOT_W      (ROOT_W)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_sample       (req_sample),
      .rsp_rms_value    (rsp_rms_value),
      .rsp_sample_count (rsp_sample_count),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

`default_nettype wire

>>> sim/rms_checker.sv
module rms_checker
   import rms_pkg::*;
#(
   parameter int unsigned MAX_SAMPLES = 1024,
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   busy,
   input  wire logic [SAMPLE_W-1:0]    req_sample,
   input  wire logic                   req_last,
   input  wire logic                   rsp_valid,
   input  wire logic [RMS_W-1:0]       rsp_rms_value,
   input  wire logic [COUNT_OUT_W-1:0] rsp_sample_count,
   input  wire logic                   rsp_overflow,
   output int                          errors,
   output int                          pending
);

   typedef struct {
      logic [RMS_W-1:0]       rms;
      logic [COUNT_OUT_W-1:0] count;
      logic                   overflow;
   } rms_word_type;

   rms_word_type expected_rms_words[$];
   logic [63:0]  sum_of_squares;
   int unsigned  samples_in_set;
   logic         set_dropped;
   int           mismatch_count;

   initial begin
      errors  = 0;
      pending = 0;
   end

   // bit-at-a-time floor square root, MSB first
   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v)
            root = trial;
      end
      return root;
   endfunction

   function automatic logic [63:0] magnitude_of(logic [SAMPLE_W-1:0] raw);
      logic [63:0] field;
      logic [63:0] span;
      span  = 64'd1 << SAMPLE_BITS;
      field = 64'(raw) & (span - 64'd1);
      if (field[SAMPLE_BITS-1])
         return span - field;
      return field;
   endfunction

   task automatic accumulate_sample(logic [SAMPLE_W-1:0] raw, logic is_last);
      logic [63:0]  sq;
      logic [63:0]  mean;
      logic [63:0]  root;
      rms_word_type w;
      if (samples_in_set < MAX_SAMPLES) begin
         sq = magnitude_of(raw) * magnitude_of(raw);
         if (sum_of_squares > ~sq)
            sum_of_squares = '1;
         else
            sum_of_squares = sum_of_squares + sq;
         samples_in_set++;
      end else begin
         set_dropped = 1'b1;
      end
      if (is_last) begin
         mean = (samples_in_set != 0) ? sum_of_squares / 64'(samples_in_set) : 64'd0;
         root = floor_root(mean);
         if (root > 64'hFFFF)
            root = 64'hFFFF;
         w.rms      = root[RMS_W-1:0];
         w.count    = samples_in_set[COUNT_OUT_W-1:0];
         w.overflow = set_dropped;
         expected_rms_words.push_back(w);
         sum_of_squares = '0;
         samples_in_set = 0;
         set_dropped    = 1'b0;
      end
   endtask

   task automatic flag_mismatch(string what, rms_word_type exp_w);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t rms word %s: exp rms %0d cnt %0d ovf %0b, got rms %0d cnt %0d ovf %0b",
                  $time, what, exp_w.rms, exp_w.count, exp_w.overflow,
                  rsp_rms_value, rsp_sample_count, rsp_overflow);
   endtask

   always @(posedge clock) begin
      rms_word_type exp_w;
      if (reset) begin
         sum_of_squares = '0;
         samples_in_set = 0;
         set_dropped    = 1'b0;
         mismatch_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_rms_words.size() == 0) begin
               exp_w = '{rms: '0, count: '0, overflow: 1'b0};
               flag_mismatch("with none pending", exp_w);
            end else begin
               exp_w = expected_rms_words.pop_front();
               if (rsp_rms_value !== exp_w.rms || rsp_sample_count !== exp_w.count ||
                   rsp_overflow !== exp_w.overflow)
                  flag_mismatch("mismatch", exp_w);
            end
         end
         if (start && !busy)
            accumulate_sample(req_sample, req_last);
      end
      errors  <= mismatch_count;
      pending <= expected_rms_words.size();
   end

endmodule

>>> sim/tb.sv
module tb;
   import rms_pkg::*;

   // run limit in cycles
   localparam int CYCLE_LIMIT   = 200000;
   // drain wait after the last result
   localparam int DRAIN_CYCLES  = 100;
   localparam int SMALL_WORDS   = 750;
   localparam int IDLE_PCT      = 12;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   start            = 1'b0;
   logic [SAMPLE_W-1:0]    req_sample       = '0;
   logic                   req_last         = 1'b0;
   logic                   busy;
   logic                   rsp_valid;
   logic [RMS_W-1:0]       rsp_rms_value;
   logic [COUNT_OUT_W-1:0] rsp_sample_count;
   logic                   rsp_overflow;

   int errors;
   int pending;
   int cycles       = 0;
   int words_sent   = 0;
   bit idle_enabled = 1'b1;

   always #10 clock = ~clock;

   root_mean_square_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample       (req_sample),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_rms_value    (rsp_rms_value),
      .rsp_sample_count (rsp_sample_count),
      .rsp_overflow     (rsp_overflow)
   );

   // watches both channels, predicts each set's result and compares
   rms_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample       (req_sample),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_rms_value    (rsp_rms_value),
      .rsp_sample_count (rsp_sample_count),
      .rsp_overflow     (rsp_overflow),
      .errors           (errors),
      .pending          (pending)
   );

   // watchdog: a hung handshake or a lost result ends here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("root_mean_square_top regression: fail");
         $finish;
      end
   end

   // sample word mix: extremes and near-zero values show up often,
   // the rest is uniform over all 16 bits
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(15))
         0: return 16'h8000;   // most negative, square is 2^30
         1: return 16'h7FFF;   // most positive
         2: return 16'h0000;
         3: return 16'hFFFF;   // -1
         4: return 16'h0001;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // one word on the request side; random idle cycles go in front of it,
   // then start stays high until an edge sees busy low
   task automatic send_word(logic [SAMPLE_W-1:0] s, logic is_last);
      while (idle_enabled && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_sample <= s;
      req_last   <= is_last;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // a set of n random words, the final one flagged last
   task automatic send_set(int n);
      for (int i = 0; i < n; i++)
         send_word(pick_sample(), i == n - 1);
      words_sent += n;
   endtask

   initial begin
      int set_no;
      int len;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed sets ---
      send_word(16'h0000, 1'b1);                 // zero sample: rms 0
      send_word(16'h8000, 1'b1);                 // -32768 alone: rms 32768
      send_word(16'h7FFF, 1'b1);                 // max positive alone
      send_word(16'hFFFF, 1'b1);                 // -1: rms 1
      // 3, -4, 5: 50 / 3 floors to 16, root 4
      send_word(16'd3, 1'b0);
      send_word(-16'sd4, 1'b0);
      send_word(16'd5, 1'b1);
      // both extremes together, plus zeros dragging the mean down
      send_word(16'h8000, 1'b0);
      send_word(16'h7FFF, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(16'h0000, 1'b1);
      // alternating bit patterns, then -2 (16'hFFFE)
      send_word(16'hAAAA, 1'b0);
      send_word(16'h5555, 1'b0);
      send_word(16'hFFFE, 1'b1);
      // run of max-magnitude words: mean stays 2^30
      repeat (5) send_word(16'h8000, 1'b0);
      send_word(16'h8000, 1'b1);
      // back-to-back singles, no idle in between
      idle_enabled = 1'b0;
      send_word(16'h0002, 1'b1);
      send_word(16'h7FFE, 1'b1);
      send_word(16'h8001, 1'b1);
      idle_enabled = 1'b1;

      // --- random sets ---
      // sets of 1 to 40 words, with single-word and very short sets weighted up
      set_no = 0;
      while (words_sent < SMALL_WORDS) begin
         // long stretch without idle cycles
         idle_enabled = !(set_no >= 20 && set_no < 35);
         len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40);
         send_set(len);
         set_no++;
      end
      start <= 1'b0;

      // drain: every expected result in, then DRAIN_CYCLES more
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("root_mean_square_top regression: pass");
      else
         $display("root_mean_square_top regression: fail");
      $finish;
   end

endmodule

>>> root_mean_square_top.f
rtl/rms_pkg.sv
rtl/rms_ctrl.sv
rtl/rms_dp.sv
rtl/root_mean_square_top.sv
sim/rms_checker.sv
sim/tb.sv
